// ===== rtl/pthc_pkg.sv =====
// ----------------------------------------------------------------------------
// pthc_pkg
// types, register indexes and shift helpers shared by the compensation block
// and its checker
// ----------------------------------------------------------------------------
package pthc_pkg;

  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
    logic [15:0] raw_humidity;
  } pthc_in_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               pressure_valid;
    logic [16:0]        humidity_q22_10;
    logic               humidity_valid;
  } pthc_out_t;

  localparam logic [2:0] CFG_TEMP_CALIB  = 3'd0;
  localparam logic [2:0] CFG_PRESS_LOW   = 3'd1;
  localparam logic [2:0] CFG_PRESS_HIGH  = 3'd2;
  localparam logic [2:0] CFG_PRESS_P9    = 3'd3;
  localparam logic [2:0] CFG_HUM_CALIB   = 3'd4;
  localparam logic [2:0] CFG_HUM_ENABLE  = 3'd5;

  localparam logic [16:0] HUM_MAX_Q10 = 17'd102400;

  function automatic logic [31:0] asr32(logic [31:0] v, int unsigned s);
    return 32'($signed(v) >>> s);
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] v, int unsigned s);
    return 64'($signed(v) >>> s);
  endfunction

endpackage

// ===== rtl/pth_sensor_integer_compensation.sv =====
// ----------------------------------------------------------------------------
// pth_sensor_integer_compensation
// integer temperature, pressure and humidity compensation, fully pipelined
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall | pthc_in_t raw conversion set
//  out     | output    | out_valid/out_stall | pthc_out_t compensated result
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_wdata
//
//  one transfer in per cycle unless stalled; the 64-bit pressure
//  division is a 64-stage restoring divider, one quotient bit per stage
//  rst_n is synchronous: clears all valid bits, reloads register defaults
//  out_stall with a result waiting freezes the whole pipeline and raises
//  in_stall in the same cycle; nothing is dropped or repeated
// ----------------------------------------------------------------------------
module pth_sensor_integer_compensation
  import pthc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  pthc_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output pthc_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam int DIV_STEPS = 64;
  localparam int NPIPE     = 13 + DIV_STEPS + 5;

  typedef struct packed {
    logic [127:0] acc;
    logic [63:0]  md;
    logic         neg;
    logic         zero;
    logic [31:0]  temp;
    logic [16:0]  hum;
  } dv_stage_t;

  // configuration
  logic [47:0] temp_calib_r;
  logic [63:0] press_lo_r, press_hi_r, hum_calib_r;
  logic [15:0] press_p9_r;
  logic        hum_en_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_calib_r <= '0;
      press_lo_r   <= '0;
      press_hi_r   <= '0;
      press_p9_r   <= '0;
      hum_calib_r  <= '0;
      hum_en_r     <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TEMP_CALIB: temp_calib_r <= cfg_wdata[47:0];
        CFG_PRESS_LOW:  press_lo_r   <= cfg_wdata;
        CFG_PRESS_HIGH: press_hi_r   <= cfg_wdata;
        CFG_PRESS_P9:   press_p9_r   <= cfg_wdata[15:0];
        CFG_HUM_CALIB:  hum_calib_r  <= cfg_wdata;
        CFG_HUM_ENABLE: hum_en_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic [31:0]        t1;
  logic signed [15:0] t2s, t3s;
  logic [15:0]        p1;
  logic signed [15:0] p2s, p3s, p4s, p5s, p6s, p7s, p8s, p9s;
  logic [7:0]         h1, h3;
  logic signed [15:0] h2s;
  logic [11:0]        h4;
  logic signed [11:0] h5s;
  logic signed [7:0]  h6s;

  assign t1  = {16'd0, temp_calib_r[47:32]};
  assign t2s = $signed(temp_calib_r[31:16]);
  assign t3s = $signed(temp_calib_r[15:0]);
  assign p1  = press_lo_r[63:48];
  assign p2s = $signed(press_lo_r[47:32]);
  assign p3s = $signed(press_lo_r[31:16]);
  assign p4s = $signed(press_lo_r[15:0]);
  assign p5s = $signed(press_hi_r[63:48]);
  assign p6s = $signed(press_hi_r[47:32]);
  assign p7s = $signed(press_hi_r[31:16]);
  assign p8s = $signed(press_hi_r[15:0]);
  assign p9s = $signed(press_p9_r);
  assign h1  = hum_calib_r[63:56];
  assign h2s = $signed(hum_calib_r[55:40]);
  assign h3  = hum_calib_r[39:32];
  assign h4  = hum_calib_r[31:20];
  assign h5s = $signed(hum_calib_r[19:8]);
  assign h6s = $signed(hum_calib_r[7:0]);

  // pipeline control
  logic             adv;
  logic [NPIPE-1:0] pv_r;
  logic             out_valid_r;
  pthc_out_t        out_data_r;

  assign in_stall  = out_valid_r & out_stall;
  assign adv       = ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      pv_r        <= {pv_r[NPIPE-2:0], in_valid};
      out_valid_r <= pv_r[NPIPE-1];
    end
  end

  // temperature, front of pressure and humidity
  logic [31:0]        r1_ta_r, r1_d_r, r2_am_r, r2_dd_r, r3_a_r, r3_bm_r, r4_fine_r;
  logic [19:0]        r1_ap_r, r2_ap_r, r3_ap_r, r4_ap_r, r5_ap_r, r6_ap_r;
  logic [19:0]        r7_ap_r, r8_ap_r, r9_ap_r;
  logic [15:0]        r1_ah_r, r2_ah_r, r3_ah_r, r4_ah_r, r5_ah_r;
  logic [31:0]        r5_temp_r, r6_temp_r, r7_temp_r, r8_temp_r, r9_temp_r;
  logic [31:0]        r10_temp_r, r11_temp_r, r12_temp_r, r13_temp_r;
  logic signed [32:0] r5_v1_r;
  logic [31:0]        r5_vh_r;
  logic [63:0]        r6_sq_r, r6_m5_r, r6_m2_r;
  logic [31:0]        r6_m5h_r, r6_y1m_r, r6_y2m_r, r6_xb_r;
  logic [63:0]        r7_t6_r, r7_t3m_r, r7_m5s_r, r7_m2s_r;
  logic [31:0]        r7_x_r, r7_y1_r, r7_y2_r;
  logic [63:0]        r8_v2_r, r8_v1b_r;
  logic [31:0]        r8_x_r, r8_yy_r;
  logic [63:0]        r9_v2_r, r9_w_r;
  logic [31:0]        r9_x_r, r9_ya_r;
  logic [63:0]        r10_den_r, r10_npre_r;
  logic [31:0]        r10_x_r, r10_y_r;
  logic [63:0]        r11_den_r, r11_num_r;
  logic [31:0]        r11_v_r;
  logic [63:0]        r12_mn_r, r12_md_r, r13_mn_r, r13_md_r;
  logic               r12_neg_r, r12_zero_r, r13_neg_r, r13_zero_r;
  logic [31:0]        r12_v_r, r12_ss_r, r13_v_r, r13_sh_r;
  logic [20:0]        pdiff;

  assign pdiff = 21'd1048576 - {1'b0, r9_ap_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      r1_ta_r <= {15'd0, in_data.raw_temperature[19:3]} - {t1[30:0], 1'b0};
      r1_d_r  <= {16'd0, in_data.raw_temperature[19:4]} - t1;
      r1_ap_r <= in_data.raw_pressure;
      r1_ah_r <= in_data.raw_humidity;

      r2_am_r <= $signed(r1_ta_r) * t2s;
      r2_dd_r <= r1_d_r * r1_d_r;
      r2_ap_r <= r1_ap_r;
      r2_ah_r <= r1_ah_r;

      r3_a_r  <= asr32(r2_am_r, 11);
      r3_bm_r <= $signed(asr32(r2_dd_r, 12)) * t3s;
      r3_ap_r <= r2_ap_r;
      r3_ah_r <= r2_ah_r;

      r4_fine_r <= r3_a_r + asr32(r3_bm_r, 14);
      r4_ap_r   <= r3_ap_r;
      r4_ah_r   <= r3_ah_r;

      r5_temp_r <= asr32(r4_fine_r * 32'd5 + 32'd128, 8);
      r5_v1_r   <= $signed({r4_fine_r[31], r4_fine_r}) - 33'sd128000;
      r5_vh_r   <= r4_fine_r - 32'd76800;
      r5_ap_r   <= r4_ap_r;
      r5_ah_r   <= r4_ah_r;

      r6_sq_r   <= r5_v1_r * r5_v1_r;
      r6_m5_r   <= r5_v1_r * p5s;
      r6_m2_r   <= r5_v1_r * p2s;
      r6_m5h_r  <= h5s * $signed(r5_vh_r);
      r6_y1m_r  <= $signed(r5_vh_r) * h6s;
      r6_y2m_r  <= $signed(r5_vh_r) * $signed({1'b0, h3});
      r6_xb_r   <= {2'd0, r5_ah_r, 14'd0} - {h4, 20'd0};
      r6_ap_r   <= r5_ap_r;
      r6_temp_r <= r5_temp_r;

      r7_t6_r   <= $signed(r6_sq_r) * p6s;
      r7_t3m_r  <= $signed(r6_sq_r) * p3s;
      r7_m5s_r  <= {r6_m5_r[46:0], 17'd0};
      r7_m2s_r  <= {r6_m2_r[51:0], 12'd0};
      r7_x_r    <= asr32(r6_xb_r - r6_m5h_r + 32'd16384, 15);
      r7_y1_r   <= asr32(r6_y1m_r, 10);
      r7_y2_r   <= asr32(r6_y2m_r, 11) + 32'd32768;
      r7_ap_r   <= r6_ap_r;
      r7_temp_r <= r6_temp_r;

      r8_v2_r   <= r7_t6_r + r7_m5s_r + {{13{p4s[15]}}, p4s, 35'd0};
      r8_v1b_r  <= asr64(r7_t3m_r, 8) + r7_m2s_r;
      r8_x_r    <= r7_x_r;
      r8_yy_r   <= r7_y1_r * r7_y2_r;
      r8_ap_r   <= r7_ap_r;
      r8_temp_r <= r7_temp_r;

      r9_w_r    <= (64'h0000_8000_0000_0000 + r8_v1b_r) * {48'd0, p1};
      r9_v2_r   <= r8_v2_r;
      r9_x_r    <= r8_x_r;
      r9_ya_r   <= (asr32(r8_yy_r, 10) + 32'd2097152) * {{16{h2s[15]}}, h2s};
      r9_ap_r   <= r8_ap_r;
      r9_temp_r <= r8_temp_r;

      r10_den_r  <= asr64(r9_w_r, 33);
      r10_npre_r <= {12'd0, pdiff, 31'd0} - r9_v2_r;
      r10_x_r    <= r9_x_r;
      r10_y_r    <= asr32(r9_ya_r + 32'd8192, 14);
      r10_temp_r <= r9_temp_r;

      r11_num_r  <= r10_npre_r * 64'd3125;
      r11_den_r  <= r10_den_r;
      r11_v_r    <= r10_x_r * r10_y_r;
      r11_temp_r <= r10_temp_r;

      r12_mn_r   <= r11_num_r[63] ? 64'd0 - r11_num_r : r11_num_r;
      r12_md_r   <= r11_den_r[63] ? 64'd0 - r11_den_r : r11_den_r;
      r12_neg_r  <= r11_num_r[63] ^ r11_den_r[63];
      r12_zero_r <= (r11_den_r == 64'd0);
      r12_v_r    <= r11_v_r;
      r12_ss_r   <= asr32(r11_v_r, 15) * asr32(r11_v_r, 15);
      r12_temp_r <= r11_temp_r;

      r13_mn_r   <= r12_mn_r;
      r13_md_r   <= r12_md_r;
      r13_neg_r  <= r12_neg_r;
      r13_zero_r <= r12_zero_r;
      r13_v_r    <= r12_v_r;
      r13_sh_r   <= asr32(r12_ss_r, 7) * {24'd0, h1};
      r13_temp_r <= r12_temp_r;
    end
  end

  // humidity finish, clamp to 0..100 percent
  logic [31:0] hum_v, hum_c;

  assign hum_v = r13_v_r - asr32(r13_sh_r, 4);
  assign hum_c = hum_v[31] ? 32'd0 :
                 (hum_v > 32'd419430400) ? 32'd419430400 : hum_v;

  // restoring divider, one quotient bit per stage
  dv_stage_t dv_r [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    dv_stage_t    prev;
    dv_stage_t    stage_nxt;
    logic [127:0] shl;
    logic [64:0]  diff;

    if (k == 0) begin : g_first
      assign prev = '{acc: {64'd0, r13_mn_r}, md: r13_md_r, neg: r13_neg_r,
                      zero: r13_zero_r, temp: r13_temp_r, hum: hum_c[28:12]};
    end else begin : g_next
      assign prev = dv_r[k-1];
    end

    assign shl  = {prev.acc[126:0], 1'b0};
    assign diff = {1'b0, shl[127:64]} - {1'b0, prev.md};

    assign stage_nxt = '{acc: diff[64] ? shl : {diff[63:0], shl[63:1], 1'b1},
                         md: prev.md, neg: prev.neg, zero: prev.zero,
                         temp: prev.temp, hum: prev.hum};

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[k] <= stage_nxt;
      end
    end
  end

  // pressure back end
  logic [63:0] r14_p_r, r15_p_r, r16_p_r, r17_p_r, r18_p_r;
  logic        r14_zero_r, r15_zero_r, r16_zero_r, r17_zero_r, r18_zero_r;
  logic [31:0] r14_temp_r, r15_temp_r, r16_temp_r, r17_temp_r, r18_temp_r;
  logic [16:0] r14_hum_r, r15_hum_r, r16_hum_r, r17_hum_r, r18_hum_r;
  logic [63:0] r15_ps_r, r16_ps_r, r15_v2m_r, r16_v2m_r, r17_v2m_r, r18_v2m_r;
  logic [63:0] r16_q9_r, r17_ll_r, r18_v1_r;
  logic [31:0] r17_hl_r, r17_lh_r;
  logic [63:0] quot, pfin;

  assign quot = dv_r[DIV_STEPS-1].acc[63:0];
  assign pfin = asr64(r18_p_r + asr64(r18_v1_r, 25) + asr64(r18_v2m_r, 19), 8)
              + {{44{p7s[15]}}, p7s, 4'd0};

  always_ff @(posedge clk) begin
    if (adv) begin
      r14_p_r    <= dv_r[DIV_STEPS-1].neg ? 64'd0 - quot : quot;
      r14_zero_r <= dv_r[DIV_STEPS-1].zero;
      r14_temp_r <= dv_r[DIV_STEPS-1].temp;
      r14_hum_r  <= dv_r[DIV_STEPS-1].hum;

      r15_ps_r   <= asr64(r14_p_r, 13);
      r15_v2m_r  <= $signed(r14_p_r) * p8s;
      r15_p_r    <= r14_p_r;
      r15_zero_r <= r14_zero_r;
      r15_temp_r <= r14_temp_r;
      r15_hum_r  <= r14_hum_r;

      r16_q9_r   <= $signed(r15_ps_r) * p9s;
      r16_ps_r   <= r15_ps_r;
      r16_v2m_r  <= r15_v2m_r;
      r16_p_r    <= r15_p_r;
      r16_zero_r <= r15_zero_r;
      r16_temp_r <= r15_temp_r;
      r16_hum_r  <= r15_hum_r;

      // low 64 bits of q9 * ps from 32-bit partial products
      r17_ll_r   <= r16_q9_r[31:0] * r16_ps_r[31:0];
      r17_hl_r   <= r16_q9_r[63:32] * r16_ps_r[31:0];
      r17_lh_r   <= r16_q9_r[31:0] * r16_ps_r[63:32];
      r17_v2m_r  <= r16_v2m_r;
      r17_p_r    <= r16_p_r;
      r17_zero_r <= r16_zero_r;
      r17_temp_r <= r16_temp_r;
      r17_hum_r  <= r16_hum_r;

      r18_v1_r   <= r17_ll_r + {r17_hl_r + r17_lh_r, 32'd0};
      r18_v2m_r  <= r17_v2m_r;
      r18_p_r    <= r17_p_r;
      r18_zero_r <= r17_zero_r;
      r18_temp_r <= r17_temp_r;
      r18_hum_r  <= r17_hum_r;

      out_data_r.temperature_centi <= $signed(r18_temp_r);
      out_data_r.pressure_q24_8    <= r18_zero_r ? 32'd0 : pfin[31:0];
      out_data_r.pressure_valid    <= ~r18_zero_r;
      out_data_r.humidity_q22_10   <= hum_en_r ? r18_hum_r : 17'd0;
      out_data_r.humidity_valid    <= hum_en_r;
    end
  end

endmodule

// ===== rtl/pthc_checker.sv =====
// ----------------------------------------------------------------------------
// pthc_checker
// port-level checks on the compensation block, attached by bind
// ----------------------------------------------------------------------------
module pthc_checker
  import pthc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input pthc_out_t out_data
);

  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.humidity_q22_10 <= HUM_MAX_Q10)
    else $error("humidity above clamp");

  a_press_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.pressure_valid |-> out_data.pressure_q24_8 == 32'd0)
    else $error("invalid pressure not zero");

  a_hum_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.humidity_valid |-> out_data.humidity_q22_10 == 17'd0)
    else $error("disabled humidity not zero");

endmodule

bind pth_sensor_integer_compensation pthc_checker u_pthc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// checks the compensation block against a local integer predictor: register
// settings, field extremes, zero pressure divisor, humidity disabled and
// random conversion sets, with bursty input and output stall
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import pthc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  pthc_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  pthc_out_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;

  pth_sensor_integer_compensation DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  localparam int LATENCY = 83;
  localparam int CYCLE_LIMIT = 400000;

  // local copy of the calibration registers
  logic [47:0] cal_temp;
  logic [63:0] cal_press_lo;
  logic [63:0] cal_press_hi;
  logic [15:0] cal_p9;
  logic [63:0] cal_hum;
  logic        hum_on;

  pthc_out_t expected_results[$];
  int  mismatches;
  int  cycles;
  bit  hold_off;
  int  hold_cycles;
  bit  steady_in;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [31:0] sr32(logic [31:0] v, int s);
    return 32'($signed(v) >>> s);
  endfunction

  function automatic logic [63:0] sr64(logic [63:0] v, int s);
    return 64'($signed(v) >>> s);
  endfunction

  function automatic logic [63:0] div_trunc(logic [63:0] n, logic [63:0] d);
    logic [63:0] mn, md, q;
    mn = n[63] ? -n : n;
    md = d[63] ? -d : d;
    q = mn / md;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function automatic pthc_out_t compensate(pthc_in_t raw);
    pthc_out_t r;
    logic [31:0] t1, t2, t3, a, d, b, fine, adc_t, adc_h;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p;
    logic [31:0] h1, h2, h3, h4, h5, h6, v, x, y1, y2, y, s;
    adc_t = 32'(raw.raw_temperature);
    adc_h = 32'(raw.raw_humidity);
    t1 = 32'(cal_temp[47:32]);
    t2 = 32'(signed'(cal_temp[31:16]));
    t3 = 32'(signed'(cal_temp[15:0]));
    a = sr32(((adc_t >> 3) - (t1 << 1)) * t2, 11);
    d = (adc_t >> 4) - t1;
    b = sr32(sr32(d * d, 12) * t3, 14);
    fine = a + b;
    r = '0;
    r.temperature_centi = sr32(fine * 32'd5 + 32'd128, 8);

    p1 = 64'(cal_press_lo[63:48]);
    p2 = 64'(signed'(cal_press_lo[47:32]));
    p3 = 64'(signed'(cal_press_lo[31:16]));
    p4 = 64'(signed'(cal_press_lo[15:0]));
    p5 = 64'(signed'(cal_press_hi[63:48]));
    p6 = 64'(signed'(cal_press_hi[47:32]));
    p7 = 64'(signed'(cal_press_hi[31:16]));
    p8 = 64'(signed'(cal_press_hi[15:0]));
    p9 = 64'(signed'(cal_p9));
    v1 = 64'(signed'(fine)) - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = sr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = sr64(((64'd1 << 47) + v1) * p1, 33);
    if (v1 != 0) begin
      p = 64'd1048576 - 64'(raw.raw_pressure);
      p = div_trunc(((p << 31) - v2) * 64'd3125, v1);
      v1 = sr64(p9 * sr64(p, 13) * sr64(p, 13), 25);
      v2 = sr64(p8 * p, 19);
      p = sr64(p + v1 + v2, 8) + (p7 << 4);
      r.pressure_q24_8 = p[31:0];
      r.pressure_valid = 1'b1;
    end

    if (hum_on) begin
      h1 = 32'(cal_hum[63:56]);
      h2 = 32'(signed'(cal_hum[55:40]));
      h3 = 32'(cal_hum[39:32]);
      h4 = 32'(signed'(cal_hum[31:20]));
      h5 = 32'(signed'(cal_hum[19:8]));
      h6 = 32'(signed'(cal_hum[7:0]));
      v = fine - 32'd76800;
      x = sr32((adc_h << 14) - (h4 << 20) - h5 * v + 32'd16384, 15);
      y1 = sr32(v * h6, 10);
      y2 = sr32(v * h3, 11) + 32'd32768;
      y = sr32((sr32(y1 * y2, 10) + 32'd2097152) * h2 + 32'd8192, 14);
      v = x * y;
      s = sr32(v, 15);
      v = v - sr32(sr32(s * s, 7) * h1, 4);
      if (v[31])
        v = 0;
      else if (v > 32'd419430400)
        v = 32'd419430400;
      r.humidity_q22_10 = v[28:12];
      r.humidity_valid = 1'b1;
    end
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    pthc_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %h", out_data);
      end else begin
        e = expected_results.pop_front();
        if (out_data.temperature_centi !== e.temperature_centi ||
            out_data.pressure_q24_8 !== e.pressure_q24_8 ||
            out_data.pressure_valid !== e.pressure_valid ||
            out_data.humidity_q22_10 !== e.humidity_q22_10 ||
            out_data.humidity_valid !== e.humidity_valid) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: temp %0d/%0d press %h/%h pv %b/%b hum %0d/%0d hv %b/%b",
                     e.temperature_centi, out_data.temperature_centi,
                     e.pressure_q24_8, out_data.pressure_q24_8,
                     e.pressure_valid, out_data.pressure_valid,
                     e.humidity_q22_10, out_data.humidity_q22_10,
                     e.humidity_valid, out_data.humidity_valid);
        end
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (hold_off)
      out_stall <= 1'b1;
    else if (cycles[9])
      out_stall <= 1'b0;
    else
      out_stall <= ($urandom_range(99) < 30);
  end

  // long hold-off, counted here
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_off <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      hold_off <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL pth_sensor_integer_compensation");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TEMP_CALIB: cal_temp = val[47:0];
      CFG_PRESS_LOW:  cal_press_lo = val;
      CFG_PRESS_HIGH: cal_press_hi = val;
      CFG_PRESS_P9:   cal_p9 = val[15:0];
      CFG_HUM_CALIB:  cal_hum = val;
      CFG_HUM_ENABLE: hum_on = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // one transfer; valid stays high when another item follows directly
  task automatic send_set(pthc_in_t raw);
    in_valid = 1'b1;
    in_data = raw;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(compensate(raw));
    @(negedge clk);
    if (!steady_in)
      in_valid = 1'b0;
  endtask

  task automatic drain;
    in_valid = 1'b0;
    while (expected_results.size() != 0)
      @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  function automatic pthc_in_t random_set();
    pthc_in_t r;
    r.raw_pressure = 20'($urandom);
    r.raw_temperature = 20'($urandom);
    r.raw_humidity = 16'($urandom);
    if ($urandom_range(3) != 0) begin
      r.raw_pressure = 20'($urandom_range(200000, 700000));
      r.raw_temperature = 20'($urandom_range(420000, 620000));
      r.raw_humidity = 16'($urandom_range(20000, 45000));
    end
    return r;
  endfunction

  // typical calibration words of a real part
  task automatic load_typical;
    write_reg(CFG_TEMP_CALIB, 64'({16'd27504, 16'd26435, -16'sd1000}));
    write_reg(CFG_PRESS_LOW, {16'd36477, -16'sd10685, 16'd3024, 16'd2855});
    write_reg(CFG_PRESS_HIGH, {16'd140, -16'sd7, 16'd15500, -16'sd14600});
    write_reg(CFG_PRESS_P9, 64'(16'd6000));
    write_reg(CFG_HUM_CALIB, {8'd75, 16'd362, 8'd0, 12'd309, 12'd50, 8'd30});
    write_reg(CFG_HUM_ENABLE, 64'd1);
  endtask

  task automatic test_reset_defaults;
    send_set('{20'd500000, 20'd520000, 16'd30000});
    send_set('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
    drain();
  endtask

  task automatic test_directed;
    load_typical();
    send_set('{20'd0, 20'd0, 16'd0});
    send_set('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
    send_set('{20'd415148, 20'd519888, 16'd30000});
    send_set('{20'd0, 20'hFFFFF, 16'd0});
    send_set('{20'hFFFFF, 20'd0, 16'hFFFF});
    send_set('{20'd1, 20'd450000, 16'd1});
    drain();
    write_reg(CFG_HUM_ENABLE, 64'd0);
    send_set('{20'd415148, 20'd519888, 16'd30000});
    drain();
    // zero pressure divisor
    write_reg(CFG_PRESS_LOW, 64'd0);
    write_reg(CFG_HUM_ENABLE, 64'd1);
    send_set('{20'd415148, 20'd519888, 16'hFFFF});
    drain();
    // register extremes, index beyond the map ignored
    write_reg(CFG_TEMP_CALIB, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_PRESS_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_PRESS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_PRESS_P9, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_HUM_CALIB, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(3'd6, 64'h0);
    write_reg(3'd7, 64'h1234);
    send_set('{20'd0, 20'd0, 16'hFFFF});
    send_set('{20'hFFFFF, 20'hFFFFF, 16'd0});
    drain();
    write_reg(CFG_TEMP_CALIB, 64'({16'hFFFF, 16'h8000, 16'h8000}));
    write_reg(CFG_PRESS_LOW, {16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF});
    write_reg(CFG_PRESS_HIGH, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
    write_reg(CFG_PRESS_P9, 64'h8000);
    write_reg(CFG_HUM_CALIB, {8'hFF, 16'h7FFF, 8'hFF, 12'h800, 12'h7FF, 8'h80});
    send_set('{20'd0, 20'd0, 16'd0});
    send_set('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
    send_set('{20'h80000, 20'h80000, 16'h8000});
    drain();
  endtask

  task automatic test_random_bursts(int count, bit random_cal);
    int burst;
    if (random_cal) begin
      write_reg(CFG_TEMP_CALIB, {$urandom, $urandom});
      write_reg(CFG_PRESS_LOW, {$urandom, $urandom});
      write_reg(CFG_PRESS_HIGH, {$urandom, $urandom});
      write_reg(CFG_PRESS_P9, 64'($urandom));
      write_reg(CFG_HUM_CALIB, {$urandom, $urandom});
      write_reg(CFG_HUM_ENABLE, 64'($urandom_range(1)));
    end
    while (count > 0) begin
      burst = $urandom_range(1, 20);
      steady_in = 1'b1;
      for (int i = 0; i < burst && count > 0; i++) begin
        if (i == burst - 1 || count == 1)
          steady_in = 1'b0;
        send_set(random_set());
        count--;
      end
      steady_in = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
    drain();
  endtask

  task automatic test_backpressure;
    load_typical();
    hold_cycles = 300;
    steady_in = 1'b1;
    for (int i = 0; i < 150; i++)
      send_set(random_set());
    steady_in = 1'b0;
    // pause until everything is out
    drain();
    send_set(random_set());
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    mismatches = 0;
    cycles = 0;
    hold_off = 1'b0;
    hold_cycles = 0;
    steady_in = 1'b0;
    cal_temp = '0;
    cal_press_lo = '0;
    cal_press_hi = '0;
    cal_p9 = '0;
    cal_hum = '0;
    hum_on = 1'b1;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_directed();
    load_typical();
    test_random_bursts(700, 1'b0);
    for (int k = 0; k < 6; k++)
      test_random_bursts(100, 1'b1);
    test_backpressure();
    load_typical();
    write_reg(CFG_HUM_ENABLE, 64'd0);
    test_random_bursts(150, 1'b0);

    if (mismatches == 0 && expected_results.size() == 0)
      $display("PASS pth_sensor_integer_compensation");
    else
      $display("FAIL pth_sensor_integer_compensation");
    $finish;
  end

endmodule
